>>> rtl/lmpf_pkg.sv
package lmpf_pkg;

  localparam int MAX_DIM    = 2048;
  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int DIM_W = 12;
  localparam int CNT_W = 11;
  localparam int PIX_W = 8;
  localparam int HW_W  = 8;

  localparam int HW_LIMIT = (RING_DEPTH - 1) / 2;
  localparam int HW_MAX   = (HW_LIMIT > 255) ? 255 : HW_LIMIT;
  localparam int HW_BASE  = 7;

  localparam int ROI_MARGIN   = 30;
  localparam int WIDTH_DEN    = 20;
  localparam int MIN_CONTRAST = 5;

  localparam int NUM_W   = 22;
  localparam int DEN_W   = 15;
  localparam int DCNT_W  = $clog2(NUM_W);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = QAW + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(640);

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_MUL,
    WS_DIV,
    WS_FIN
  } lmpf_wstate_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] row;
    logic [HW_W-1:0]  hw;
  } lmpf_wres_t;

  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] lft;
    logic [PIX_W-1:0] rgt;
  } lmpf_job_t;

endpackage

>>> rtl/lane_marking_pixel_filter.sv
// Lane marking pixel filter: dark-light-dark test on a grey raster stream.
// Input queue side: drive in_gray_pixel with in_push; a pixel is taken on a
// clock edge with in_push high and in_full low. Pixels arrive in raster order;
// row and column are counted inside.
// Result queue side: while out_empty is low the oldest result (row, column,
// marking flag of a judged centre pixel) is on out_*; out_pop takes it.
// Configuration: cfg_index 0 = frame rows, 1 = frame columns, written with
// cfg_valid (cfg_ready is always high); other indexes are ignored.
// Throughput: one pixel per cycle inside a row while the queue has room. The
// half width of each row comes from a one-bit-per-cycle divider that runs
// during the previous row, so column 0 stalls only on rows shorter than its
// run, at the first row after reset and after a configuration write.
// A result goes through the job register, the queue and the output register.
// A 4-entry queue sits between the ring-buffer front and the judge stage;
// when the receiver stalls, in_full rises once that queue fills.
// Reset: frame is 480 x 640, counters at row 0 column 0, no results pending.
module lane_marking_pixel_filter
  import lmpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [PIX_W-1:0]     in_gray_pixel,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [CNT_W-1:0]     out_pixel_row,
  output logic [CNT_W-1:0]     out_pixel_col,
  output logic                 out_is_marking,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic           job_valid;
  lmpf_job_t      job;
  lmpf_job_t      q_job;
  logic           q_empty;
  logic           q_pop;
  logic [QLW-1:0] q_level;

  lmpf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_gray_pixel (in_gray_pixel),
    .in_full       (in_full),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_level       (q_level),
    .job_valid     (job_valid),
    .job           (job)
  );

  lmpf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_valid),
    .din   (job),
    .pop   (q_pop),
    .dout  (q_job),
    .empty (q_empty),
    .level (q_level)
  );

  lmpf_judge u_judge (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (q_job),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pixel_row  (out_pixel_row),
    .out_pixel_col  (out_pixel_col),
    .out_is_marking (out_is_marking)
  );

endmodule

>>> rtl/lmpf_ram.sv
module lmpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> rtl/lmpf_width.sv
module lmpf_width
  import lmpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             flush,
  input  logic [CNT_W-1:0] want_row,
  input  logic [DIM_W-1:0] rows,
  input  logic [DIM_W-1:0] cols,
  output lmpf_wres_t       wres
);

  lmpf_wstate_t      state_r, state_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [HW_W-1:0]   hw_r, hw_nxt;
  logic              neg_r, neg_nxt;
  logic              hzero_r, hzero_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;

  logic [CNT_W-1:0]  half;
  logic signed [DIM_W-1:0]   diff;
  logic signed [DIM_W+12:0]  prod;
  logic [DIM_W+12:0]         mag;
  logic [DEN_W:0]            rem_sh;
  logic [NUM_W:0]            negq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= WS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    hw_r    <= hw_nxt;
    neg_r   <= neg_nxt;
    hzero_r <= hzero_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    row_nxt   = row_r;
    hw_nxt    = hw_r;
    neg_nxt   = neg_r;
    hzero_nxt = hzero_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;

    half   = rows[DIM_W-1:1];
    diff   = $signed({1'b0, row_r}) - $signed({1'b0, half});
    prod   = $signed({1'b0, cols}) * diff;
    mag    = prod[DIM_W+12] ? (DIM_W+13)'(-prod) : prod;
    rem_sh = {rem_r, num_r[NUM_W-1]};
    negq   = {1'b0, num_r} + (NUM_W+1)'(rem_r != '0);

    case (state_r)
      WS_IDLE: begin
        if (!flush && (!done_r || row_r != want_row)) begin
          row_nxt   = want_row;
          done_nxt  = 1'b0;
          state_nxt = WS_MUL;
        end
      end
      WS_MUL: begin
        num_nxt   = mag[NUM_W-1:0];
        neg_nxt   = prod[DIM_W+12];
        hzero_nxt = (half == '0);
        den_nxt   = DEN_W'(half * WIDTH_DEN);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = WS_DIV;
      end
      WS_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
          num_nxt = {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DEN_W-1:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(NUM_W - 1)) begin
          state_nxt = WS_FIN;
        end
      end
      WS_FIN: begin
        if (hzero_r) begin
          hw_nxt = HW_W'(HW_BASE);
        end else if (neg_r) begin
          if (negq >= (NUM_W+1)'(HW_BASE - 1)) begin
            hw_nxt = HW_W'(1);
          end else begin
            hw_nxt = HW_W'(HW_BASE) - HW_W'(negq[2:0]);
          end
        end else begin
          if (num_r >= NUM_W'(HW_MAX - HW_BASE)) begin
            hw_nxt = HW_W'(HW_MAX);
          end else begin
            hw_nxt = HW_W'(num_r[HW_W-1:0] + HW_W'(HW_BASE));
          end
        end
        done_nxt  = 1'b1;
        state_nxt = WS_IDLE;
      end
      default: begin
        state_nxt = WS_IDLE;
      end
    endcase

    if (flush) begin
      done_nxt  = 1'b0;
      state_nxt = WS_IDLE;
    end
  end

  assign wres.done = done_r;
  assign wres.row  = row_r;
  assign wres.hw   = hw_r;

endmodule

>>> rtl/lmpf_front.sv
module lmpf_front
  import lmpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [PIX_W-1:0]     in_gray_pixel,
  output logic                 in_full,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic [QLW-1:0]       q_level,
  output logic                 job_valid,
  output lmpf_job_t            job
);

  logic [DIM_W-1:0] rows_cfg_r, rows_cfg_nxt;
  logic [DIM_W-1:0] cols_cfg_r, cols_cfg_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [HW_W-1:0]  hw_r, hw_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] prow_r;
  logic [CNT_W-1:0] pcol_r;
  logic [PIX_W-1:0] ppix_r;

  logic [DIM_W-1:0] rows, cols;
  logic [CNT_W-1:0] half;
  logic [DIM_W-1:0] col_inc, row_inc, row_marg;
  logic [CNT_W-1:0] next_row, want_row;
  logic [HW_W-1:0]  w_use;
  logic [HW_W:0]    two_w;
  logic [CNT_W-1:0] ctr_col, lft_col;
  logic             accept, in_roi, judge, w_ready, q_room, flush;
  logic [PIX_W-1:0] ram_ctr, ram_lft;
  lmpf_wres_t       wres;

  assign rows = (rows_cfg_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_cfg_r;
  assign cols = (cols_cfg_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_cfg_r;
  assign half = rows[DIM_W-1:1];

  assign col_inc  = {1'b0, col_r} + DIM_W'(1);
  assign row_inc  = {1'b0, row_r} + DIM_W'(1);
  assign next_row = (row_inc >= rows) ? '0 : row_inc[CNT_W-1:0];
  assign want_row = (col_r == '0) ? row_r : next_row;

  assign flush     = cfg_valid && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS);
  assign cfg_ready = 1'b1;

  assign w_ready = wres.done && (wres.row == row_r);
  assign q_room  = ({1'b0, q_level} + (QLW+1)'(pend_r)) < (QLW+1)'(QDEPTH);
  assign in_full = !q_room || ((col_r == '0) && !w_ready);
  assign accept  = in_push && !in_full;

  assign w_use    = (col_r == '0) ? wres.hw : hw_r;
  assign two_w    = {w_use, 1'b0};
  assign ctr_col  = col_r - CNT_W'(w_use);
  assign lft_col  = col_r - CNT_W'(two_w);
  assign row_marg = {1'b0, row_r} + DIM_W'(ROI_MARGIN);
  assign in_roi   = (row_marg >= {1'b0, half}) && (row_marg < rows);
  assign judge    = in_roi && (col_r >= CNT_W'(two_w)) && ({1'b0, col_r} < cols);

  lmpf_width u_width (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (flush),
    .want_row (want_row),
    .rows     (rows),
    .cols     (cols),
    .wres     (wres)
  );

  lmpf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (col_r[RING_AW-1:0]),
    .wr_data   (in_gray_pixel),
    .rd_addr_a (ctr_col[RING_AW-1:0]),
    .rd_data_a (ram_ctr),
    .rd_addr_b (lft_col[RING_AW-1:0]),
    .rd_data_b (ram_lft)
  );

  always_comb begin
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    hw_nxt       = hw_r;
    pend_nxt     = accept && judge;
    if (cfg_valid && cfg_index == CFG_ROWS) begin
      rows_cfg_nxt = cfg_data;
    end
    if (cfg_valid && cfg_index == CFG_COLS) begin
      cols_cfg_nxt = cfg_data;
    end
    if (accept) begin
      if (col_r == '0) begin
        hw_nxt = wres.hw;
      end
      if (col_inc >= cols) begin
        col_nxt = '0;
        row_nxt = next_row;
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ROWS_RESET;
      cols_cfg_r <= COLS_RESET;
      row_r      <= '0;
      col_r      <= '0;
      hw_r       <= '0;
      pend_r     <= 1'b0;
    end else begin
      rows_cfg_r <= rows_cfg_nxt;
      cols_cfg_r <= cols_cfg_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      hw_r       <= hw_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prow_r <= row_r;
      pcol_r <= ctr_col;
      ppix_r <= in_gray_pixel;
    end
  end

  assign job_valid = pend_r;
  assign job.row   = prow_r;
  assign job.col   = pcol_r;
  assign job.ctr   = ram_ctr;
  assign job.lft   = ram_lft;
  assign job.rgt   = ppix_r;

endmodule

>>> rtl/lmpf_queue.sv
module lmpf_queue
  import lmpf_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lmpf_job_t      din,
  input  logic           pop,
  output lmpf_job_t      dout,
  output logic           empty,
  output logic [QLW-1:0] level
);

  lmpf_job_t        slot_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QLW-1:0]   cnt_r, cnt_nxt;
  logic             do_pop;

  assign empty  = (cnt_r == '0);
  assign level  = cnt_r;
  assign dout   = slot_r[rp_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wp_nxt  = push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + QLW'(push) - QLW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

endmodule

>>> rtl/lmpf_judge.sv
module lmpf_judge
  import lmpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  lmpf_job_t        q_job,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [CNT_W-1:0] out_pixel_row,
  output logic [CNT_W-1:0] out_pixel_col,
  output logic             out_is_marking
);

  logic             ovld_r, ovld_nxt;
  logic [CNT_W-1:0] orow_r;
  logic [CNT_W-1:0] ocol_r;
  logic             omark_r;

  logic signed [PIX_W:0]   ld, rd, mn;
  logic signed [PIX_W+1:0] dmin2;
  logic                    mark, load;

  always_comb begin
    ld    = $signed({1'b0, q_job.ctr}) - $signed({1'b0, q_job.lft});
    rd    = $signed({1'b0, q_job.ctr}) - $signed({1'b0, q_job.rgt});
    mn    = (ld < rd) ? ld : rd;
    dmin2 = {mn, 1'b0};
    mark  = (ld > 0) && (rd > 0) && (dmin2 > (PIX_W+2)'(MIN_CONTRAST)) &&
            (dmin2 >= $signed({3'b000, q_job.ctr[PIX_W-1:1]}));
  end

  assign load     = !q_empty && (!ovld_r || out_pop);
  assign q_pop    = load;
  assign ovld_nxt = load || (ovld_r && !out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      orow_r  <= q_job.row;
      ocol_r  <= q_job.col;
      omark_r <= mark;
    end
  end

  assign out_empty      = !ovld_r;
  assign out_pixel_row  = orow_r;
  assign out_pixel_col  = ocol_r;
  assign out_is_marking = omark_r;

endmodule
